// File: hw/rtl/msde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msde_pkg: shared types and constants for the MIPS subset decode/execute
// Opcode and function codes, ALU operation codes and the decoded control word.
// ----------------------------------------------------------------------------
package msde_pkg;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // Function codes of the SPECIAL opcode
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    localparam logic [31:0] JUMP_REGION_MASK = 32'hf000_0000;
    localparam logic [4:0]  LINK_REG         = 5'd31;
    localparam logic [31:0] PC_STEP          = 32'd4;
    localparam logic [31:0] PC_LINK_STEP     = 32'd8;

    typedef enum logic [3:0] {
        ALU_ZERO,
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_NOR,
        ALU_SLTU,
        ALU_SLL,
        ALU_SRL,
        ALU_LUI,
        ALU_LINK
    } alu_op_t;

    typedef enum logic [1:0] {
        OPB_RT,
        OPB_SEXT,
        OPB_ZEXT
    } opb_sel_t;

    typedef struct packed {
        alu_op_t    alu_op;
        opb_sel_t   opb_sel;
        logic [4:0] dest_reg;
        logic       reg_write;
        logic       mem_read;
        logic       mem_write;
        logic       jump;
        logic       jump_reg;
        logic       branch_eq;
        logic       branch_ne;
        logic       illegal;
    } ctrl_t;

endpackage
`default_nettype wire

// File: hw/rtl/msde_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msde_decode: instruction decoder
// Map one instruction word onto the control word used by the execute logic.
// ----------------------------------------------------------------------------
module msde_decode (
    input  wire logic [31:0]    instr_word,
    output msde_pkg::ctrl_t     ctrl
);
    import msde_pkg::*;

    logic [5:0] opcode;
    logic [5:0] funct;
    logic [4:0] rt_field;
    logic [4:0] rd_field;

    assign opcode   = instr_word[31:26];
    assign funct    = instr_word[5:0];
    assign rt_field = instr_word[20:16];
    assign rd_field = instr_word[15:11];

    always_comb
    begin
        ctrl = '{alu_op: ALU_ZERO, opb_sel: OPB_RT, dest_reg: '0, reg_write: 1'b0,
                 mem_read: 1'b0, mem_write: 1'b0, jump: 1'b0, jump_reg: 1'b0,
                 branch_eq: 1'b0, branch_ne: 1'b0, illegal: 1'b0};
        case (opcode)
            OP_SPECIAL:
            begin
                ctrl.reg_write = 1'b1;
                ctrl.dest_reg  = rd_field;
                case (funct)
                    FN_ADDU: ctrl.alu_op = ALU_ADD;
                    FN_SUBU: ctrl.alu_op = ALU_SUB;
                    FN_AND:  ctrl.alu_op = ALU_AND;
                    FN_OR:   ctrl.alu_op = ALU_OR;
                    FN_NOR:  ctrl.alu_op = ALU_NOR;
                    FN_SLTU: ctrl.alu_op = ALU_SLTU;
                    FN_SLL:  ctrl.alu_op = ALU_SLL;
                    FN_SRL:  ctrl.alu_op = ALU_SRL;
                    FN_JR:
                    begin
                        ctrl.reg_write = 1'b0;
                        ctrl.dest_reg  = '0;
                        ctrl.jump_reg  = 1'b1;
                    end
                    default:
                    begin
                        ctrl.reg_write = 1'b0;
                        ctrl.dest_reg  = '0;
                        ctrl.illegal   = 1'b1;
                    end
                endcase
            end
            OP_J:
            begin
                ctrl.jump = 1'b1;
            end
            OP_JAL:
            begin
                ctrl.jump      = 1'b1;
                ctrl.reg_write = 1'b1;
                ctrl.dest_reg  = LINK_REG;
                ctrl.alu_op    = ALU_LINK;
            end
            OP_ADDIU, OP_SLTIU, OP_ANDI, OP_ORI, OP_LUI, OP_LW:
            begin
                ctrl.reg_write = 1'b1;
                ctrl.dest_reg  = rt_field;
                ctrl.opb_sel   = OPB_SEXT;
                case (opcode)
                    OP_SLTIU: ctrl.alu_op = ALU_SLTU;
                    OP_ANDI:
                    begin
                        ctrl.alu_op  = ALU_AND;
                        ctrl.opb_sel = OPB_ZEXT;
                    end
                    OP_ORI:
                    begin
                        ctrl.alu_op  = ALU_OR;
                        ctrl.opb_sel = OPB_ZEXT;
                    end
                    OP_LUI:   ctrl.alu_op = ALU_LUI;
                    OP_LW:
                    begin
                        ctrl.alu_op   = ALU_ADD;
                        ctrl.mem_read = 1'b1;
                    end
                    default:  ctrl.alu_op = ALU_ADD;
                endcase
            end
            OP_SW:
            begin
                ctrl.alu_op    = ALU_ADD;
                ctrl.opb_sel   = OPB_SEXT;
                ctrl.mem_write = 1'b1;
            end
            OP_BEQ:
            begin
                ctrl.alu_op    = ALU_SUB;
                ctrl.branch_eq = 1'b1;
            end
            OP_BNE:
            begin
                ctrl.alu_op    = ALU_SUB;
                ctrl.branch_ne = 1'b1;
            end
            default:
            begin
                ctrl.illegal = 1'b1;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/msde_execute.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msde_execute: ALU and next-PC logic
// Compute the ALU value, store data and PC redirect of one decoded instruction.
// ----------------------------------------------------------------------------
module msde_execute (
    input  wire msde_pkg::ctrl_t ctrl,
    input  wire logic [31:0]     instr_word,
    input  wire logic [31:0]     instr_pc,
    input  wire logic [31:0]     rs_value,
    input  wire logic [31:0]     rt_value,
    output logic [31:0]          alu_result,
    output logic [31:0]          store_data,
    output logic                 redirect,
    output logic [31:0]          redirect_target
);
    import msde_pkg::*;

    logic [15:0] imm;
    logic [31:0] simm;
    logic [31:0] opb;
    logic [4:0]  shamt;
    logic [31:0] pc_plus4;
    logic [31:0] jump_target;
    logic [31:0] branch_target;
    logic        result_zero;
    logic        branch_taken;

    assign imm      = instr_word[15:0];
    assign simm     = {{16{imm[15]}}, imm};
    assign shamt    = instr_word[10:6];
    assign pc_plus4 = instr_pc + PC_STEP;

    always_comb
    begin
        case (ctrl.opb_sel)
            OPB_SEXT: opb = simm;
            OPB_ZEXT: opb = {16'h0000, imm};
            default:  opb = rt_value;
        endcase
    end

    always_comb
    begin
        case (ctrl.alu_op)
            ALU_ADD:  alu_result = rs_value + opb;
            ALU_SUB:  alu_result = rs_value - opb;
            ALU_AND:  alu_result = rs_value & opb;
            ALU_OR:   alu_result = rs_value | opb;
            ALU_NOR:  alu_result = ~(rs_value | opb);
            ALU_SLTU: alu_result = {31'd0, (rs_value < opb)};
            ALU_SLL:  alu_result = rt_value << shamt;
            ALU_SRL:  alu_result = rt_value >> shamt;
            ALU_LUI:  alu_result = {imm, 16'h0000};
            ALU_LINK: alu_result = instr_pc + PC_LINK_STEP;
            default:  alu_result = '0;
        endcase
    end

    assign result_zero   = (alu_result == 32'd0);
    assign branch_taken  = (ctrl.branch_eq & result_zero) | (ctrl.branch_ne & ~result_zero);
    assign jump_target   = (pc_plus4 & JUMP_REGION_MASK) | {4'h0, instr_word[25:0], 2'b00};
    assign branch_target = pc_plus4 + {simm[29:0], 2'b00};

    assign store_data = ctrl.mem_write ? rt_value : 32'd0;
    assign redirect   = ctrl.jump | ctrl.jump_reg | branch_taken;

    always_comb
    begin
        if (ctrl.jump_reg)
        begin
            redirect_target = rs_value;
        end
        else if (ctrl.jump)
        begin
            redirect_target = jump_target;
        end
        else if (branch_taken)
        begin
            redirect_target = branch_target;
        end
        else
        begin
            redirect_target = '0;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/mips_subset_decode_execute.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mips_subset_decode_execute: decode and execute of a MIPS32 integer subset
// Registered input stage, one pass of decode and ALU logic, registered result.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------
//  input   | in_valid  | in_stall  | instr_word, instr_pc, rs_value, rt_value
//  result  | out_valid | out_stall | alu_result, dest_reg, reg_write, mem_read,
//          |           |           | mem_write, store_data, redirect,
//          |           |           | redirect_target, illegal
//
//  One item per cycle sustained while out_stall is low; an accepted item passes
//  the input register, then the result register, before it shows at the result
//  port.
//  The two register stages advance independently: the input stage refills as
//  soon as the result register takes its item, so a full pipe holds two items.
//  in_stall rises only when both stages hold an item and out_stall is high.
//  Reset clears the valid flags only; payload registers are not reset.
//
module mips_subset_decode_execute (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] instr_word,
    input  wire logic [31:0] instr_pc,
    input  wire logic [31:0] rs_value,
    input  wire logic [31:0] rt_value,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      alu_result,
    output logic [4:0]       dest_reg,
    output logic             reg_write,
    output logic             mem_read,
    output logic             mem_write,
    output logic [31:0]      store_data,
    output logic             redirect,
    output logic [31:0]      redirect_target,
    output logic             illegal
);
    import msde_pkg::*;

    // Input stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] s1_word_reg;
    logic [31:0] s1_pc_reg;
    logic [31:0] s1_rs_reg;
    logic [31:0] s1_rt_reg;

    // Result stage
    logic        s2_valid_reg;
    logic        s2_valid_next;
    logic [31:0] alu_result_reg;
    logic [4:0]  dest_reg_reg;
    logic        reg_write_reg;
    logic        mem_read_reg;
    logic        mem_write_reg;
    logic [31:0] store_data_reg;
    logic        redirect_reg;
    logic [31:0] redirect_target_reg;
    logic        illegal_reg;

    // Handshake
    logic        s2_load;
    logic        s1_load;
    logic        in_accept;

    // Combinational results of the input stage
    ctrl_t       ctrl;
    logic [31:0] ex_alu_result;
    logic [31:0] ex_store_data;
    logic        ex_redirect;
    logic [31:0] ex_redirect_target;

    // The result register loads when empty or when its item leaves this cycle;
    // the input register loads when empty or when its item moves on.
    assign s2_load   = ~s2_valid_reg | ~out_stall;
    assign s1_load   = ~s1_valid_reg | s2_load;
    assign in_stall  = ~s1_load;
    assign in_accept = in_valid & s1_load;

    assign s1_valid_next = s1_load ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_load ? s1_valid_reg : s2_valid_reg;

    msde_decode u_decode (
        .instr_word (s1_word_reg),
        .ctrl       (ctrl)
    );

    msde_execute u_execute (
        .ctrl            (ctrl),
        .instr_word      (s1_word_reg),
        .instr_pc        (s1_pc_reg),
        .rs_value        (s1_rs_reg),
        .rt_value        (s1_rt_reg),
        .alu_result      (ex_alu_result),
        .store_data      (ex_store_data),
        .redirect        (ex_redirect),
        .redirect_target (ex_redirect_target)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Capture a new item only on acceptance; hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_word_reg <= instr_word;
            s1_pc_reg   <= instr_pc;
            s1_rs_reg   <= rs_value;
            s1_rt_reg   <= rt_value;
        end
    end

    // Advance the finished item into the result register; hold while stalled.
    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            alu_result_reg      <= ex_alu_result;
            dest_reg_reg        <= ctrl.dest_reg;
            reg_write_reg       <= ctrl.reg_write;
            mem_read_reg        <= ctrl.mem_read;
            mem_write_reg       <= ctrl.mem_write;
            store_data_reg      <= ex_store_data;
            redirect_reg        <= ex_redirect;
            redirect_target_reg <= ex_redirect_target;
            illegal_reg         <= ctrl.illegal;
        end
    end

    assign out_valid       = s2_valid_reg;
    assign alu_result      = alu_result_reg;
    assign dest_reg        = dest_reg_reg;
    assign reg_write       = reg_write_reg;
    assign mem_read        = mem_read_reg;
    assign mem_write       = mem_write_reg;
    assign store_data      = store_data_reg;
    assign redirect        = redirect_reg;
    assign redirect_target = redirect_target_reg;
    assign illegal         = illegal_reg;

`ifndef SYNTHESIS
    // An illegal instruction writes, loads, stores and redirects nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && illegal) |-> (!reg_write && !mem_read && !mem_write && !redirect))
        else $error("illegal instruction produced a side effect");

    // No write-back means no destination register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !reg_write) |-> (dest_reg == 5'd0))
        else $error("dest_reg non-zero without reg_write");

    // A result without redirect carries a zero target.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !redirect) |-> (redirect_target == 32'd0))
        else $error("redirect_target non-zero without redirect");

    // Loads and stores are exclusive, and a store does not write back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mem_write) |-> (!mem_read && !reg_write))
        else $error("store combined with load or write-back");

    // The input side stalls only when the whole pipe is full and blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid && out_stall))
        else $error("input stalled with room in the pipe");
`endif

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for mips_subset_decode_execute
// A short directed set covers every opcode, every function code, the immediate
// and jump-target corner cases and illegal words. A long random run follows,
// mostly legal instructions with random fields plus raw noise words. Bursty
// input and a changing stall pattern at the output exercise the handshakes.
// Every result is checked field by field against an in-bench decoder.
// ----------------------------------------------------------------------------
module tb_top;

    import msde_pkg::*;

    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_POINT  = 350;   // pause the sender here until empty
    localparam int IDLE_LIMIT   = 2000;  // cycles with no handshake at all
    localparam int TAIL_CYCLES  = 8;     // pipe is two stages deep

    // One decoded and executed instruction, in port order.
    typedef struct packed {
        logic [31:0] alu_result;
        logic [4:0]  dest_reg;
        logic        reg_write;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] store_data;
        logic        redirect;
        logic [31:0] redirect_target;
        logic        illegal;
    } exec_result_t;

    typedef enum {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PATTERN
    } stall_mode_t;

    // ------------------------------------------------------------------------
    // Decoder model and ledger of results still owed by the block
    // ------------------------------------------------------------------------
    class exec_tracker;
        exec_result_t results_due[$];
        int           mismatches;
        int           n_checked;
        int           n_redirect;
        int           n_illegal;
        int           n_mem;

        function exec_result_t exec_instr(logic [31:0] w, logic [31:0] pc,
                                          logic [31:0] a, logic [31:0] b);
            exec_result_t r;
            logic [5:0]   op;
            logic [5:0]   fn;
            logic [4:0]   rt;
            logic [4:0]   rd;
            logic [4:0]   sh;
            logic [31:0]  imm_z;
            logic [31:0]  imm_s;
            logic [31:0]  pc4;
            r     = '0;
            op    = w[31:26];
            rt    = w[20:16];
            rd    = w[15:11];
            sh    = w[10:6];
            fn    = w[5:0];
            imm_z = {16'h0000, w[15:0]};
            imm_s = {{16{w[15]}}, w[15:0]};
            pc4   = pc + PC_STEP;
            case (op)
                OP_SPECIAL:
                begin
                    r.reg_write = 1'b1;
                    r.dest_reg  = rd;
                    case (fn)
                        FN_ADDU: r.alu_result = a + b;
                        FN_SUBU: r.alu_result = a - b;
                        FN_AND:  r.alu_result = a & b;
                        FN_OR:   r.alu_result = a | b;
                        FN_NOR:  r.alu_result = ~(a | b);
                        FN_SLTU: r.alu_result = {31'd0, a < b};
                        FN_SLL:  r.alu_result = b << sh;
                        FN_SRL:  r.alu_result = b >> sh;
                        FN_JR:
                        begin
                            r.reg_write       = 1'b0;
                            r.dest_reg        = '0;
                            r.redirect        = 1'b1;
                            r.redirect_target = a;
                        end
                        default:
                        begin
                            r.reg_write = 1'b0;
                            r.dest_reg  = '0;
                            r.illegal   = 1'b1;
                        end
                    endcase
                end
                OP_J, OP_JAL:
                begin
                    r.redirect        = 1'b1;
                    r.redirect_target = (pc4 & JUMP_REGION_MASK) | {4'h0, w[25:0], 2'b00};
                    if (op == OP_JAL)
                    begin
                        r.reg_write  = 1'b1;
                        r.dest_reg   = LINK_REG;
                        r.alu_result = pc + PC_LINK_STEP;
                    end
                end
                OP_ADDIU:
                begin
                    r.reg_write  = 1'b1;
                    r.dest_reg   = rt;
                    r.alu_result = a + imm_s;
                end
                OP_SLTIU:
                begin
                    r.reg_write  = 1'b1;
                    r.dest_reg   = rt;
                    r.alu_result = {31'd0, a < imm_s};
                end
                OP_ANDI:
                begin
                    r.reg_write  = 1'b1;
                    r.dest_reg   = rt;
                    r.alu_result = a & imm_z;
                end
                OP_ORI:
                begin
                    r.reg_write  = 1'b1;
                    r.dest_reg   = rt;
                    r.alu_result = a | imm_z;
                end
                OP_LUI:
                begin
                    r.reg_write  = 1'b1;
                    r.dest_reg   = rt;
                    r.alu_result = {w[15:0], 16'h0000};
                end
                OP_LW:
                begin
                    r.reg_write  = 1'b1;
                    r.dest_reg   = rt;
                    r.mem_read   = 1'b1;
                    r.alu_result = a + imm_s;
                end
                OP_SW:
                begin
                    r.mem_write  = 1'b1;
                    r.store_data = b;
                    r.alu_result = a + imm_s;
                end
                OP_BEQ, OP_BNE:
                begin
                    r.alu_result = a - b;
                    if ((op == OP_BEQ) == (r.alu_result == 32'd0))
                    begin
                        r.redirect        = 1'b1;
                        r.redirect_target = pc4 + (imm_s << 2);
                    end
                end
                default: r.illegal = 1'b1;
            endcase
            return r;
        endfunction

        function void note_instr(logic [31:0] w, logic [31:0] pc,
                                 logic [31:0] a, logic [31:0] b);
            results_due.push_back(exec_instr(w, pc, a, b));
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch on result %0d, %s: expected %h, got %h",
                             n_checked, field, want, got);
            end
        endfunction

        function void check_result(exec_result_t got);
            exec_result_t want;
            if (results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing outstanding: %h", got);
                return;
            end
            want = results_due.pop_front();
            compare_field("alu_result", want.alu_result, got.alu_result);
            compare_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
            compare_field("reg_write", 32'(want.reg_write), 32'(got.reg_write));
            compare_field("mem_read", 32'(want.mem_read), 32'(got.mem_read));
            compare_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
            compare_field("store_data", want.store_data, got.store_data);
            compare_field("redirect", 32'(want.redirect), 32'(got.redirect));
            compare_field("redirect_target", want.redirect_target, got.redirect_target);
            compare_field("illegal", 32'(want.illegal), 32'(got.illegal));
            n_checked++;
            if (want.redirect)
                n_redirect++;
            if (want.illegal)
                n_illegal++;
            if (want.mem_read || want.mem_write)
                n_mem++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [31:0] instr_word = '0;
    logic [31:0] instr_pc   = '0;
    logic [31:0] rs_value   = '0;
    logic [31:0] rt_value   = '0;
    logic        out_stall  = 1'b0;

    wire logic        in_stall;
    wire logic        out_valid;
    wire logic [31:0] alu_result;
    wire logic [4:0]  dest_reg;
    wire logic        reg_write;
    wire logic        mem_read;
    wire logic        mem_write;
    wire logic [31:0] store_data;
    wire logic        redirect;
    wire logic [31:0] redirect_target;
    wire logic        illegal;

    exec_tracker tracker = new;
    int          idle_cycles = 0;
    int          n_sent = 0;
    int          burst_left = 0;

    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left = 0;
    logic [7:0]  stall_pattern = '0;

    // Function codes and opcodes of the subset, for random picks.
    logic [5:0] fn_list [9] = '{FN_SLL, FN_SRL, FN_JR, FN_ADDU, FN_SUBU,
                                FN_AND, FN_OR, FN_NOR, FN_SLTU};
    logic [5:0] op_list [11] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU, OP_SLTIU,
                                 OP_ANDI, OP_ORI, OP_LUI, OP_LW, OP_SW};

    always #6 clk = ~clk;

    mips_subset_decode_execute u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .instr_word      (instr_word),
        .instr_pc        (instr_pc),
        .rs_value        (rs_value),
        .rt_value        (rt_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .alu_result      (alu_result),
        .dest_reg        (dest_reg),
        .reg_write       (reg_write),
        .mem_read        (mem_read),
        .mem_write       (mem_write),
        .store_data      (store_data),
        .redirect        (redirect),
        .redirect_target (redirect_target),
        .illegal         (illegal)
    );

    // ------------------------------------------------------------------------
    // Handshake monitor: both channels are sampled at the edge, before any
    // register or driven input moves, so ordering within the step cannot matter.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.check_result({alu_result, dest_reg, reg_write, mem_read,
                                      mem_write, store_data, redirect,
                                      redirect_target, illegal});
            if (in_valid && !in_stall)
                tracker.note_instr(instr_word, instr_pc, rs_value, rt_value);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: switch between no stalls, light and heavy random stalls and a
    // repeating pattern from an 8-bit mask, each held for a random stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (mode_left == 0)
        begin
            stall_mode    <= stall_mode_t'($urandom_range(0, 3));
            mode_left     <= $urandom_range(16, 128);
            stall_pattern <= 8'($urandom());
            out_stall     <= 1'b0;
        end
        else
        begin
            mode_left <= mode_left - 1;
            case (stall_mode)
                STALL_NONE:    out_stall <= 1'b0;
                STALL_LIGHT:   out_stall <= ($urandom_range(0, 2) == 0);
                STALL_HEAVY:   out_stall <= ($urandom_range(0, 9) != 0);
                STALL_PATTERN: out_stall <= stall_pattern[mode_left % 8];
                default:       out_stall <= 1'b0;
            endcase
        end
    end

    // Watchdog: give up once nothing has moved on either channel for too long.
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("handshake timeout, %0d results still outstanding",
                 tracker.results_due.size());
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Instruction encoders and operand pickers
    // ------------------------------------------------------------------------
    function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_j(logic [5:0] op, logic [25:0] index);
        return {op, index};
    endfunction

    // Bias towards the values where carries, signs and compares turn over.
    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // Mostly legal words with random fields; one in ten is raw noise.
    function automatic logic [31:0] rand_instr();
        logic [31:0] raw;
        int          pick;
        raw  = $urandom();
        pick = $urandom_range(0, 19);
        if (pick < 2)
            return raw;
        else if (pick < 9)
            return {OP_SPECIAL, raw[25:6], fn_list[$urandom_range(0, 8)]};
        else
            return {op_list[$urandom_range(0, 10)], raw[25:0]};
    endfunction

    // ------------------------------------------------------------------------
    // Driver tasks: drive at the edge, hold the item until it is taken
    // ------------------------------------------------------------------------
    task automatic send_instr(input logic [31:0] w, input logic [31:0] pc,
                              input logic [31:0] a, input logic [31:0] b);
        in_valid   <= 1'b1;
        instr_word <= w;
        instr_pc   <= pc;
        rs_value   <= a;
        rt_value   <= b;
        do
            @(posedge clk);
        while (in_stall);
        n_sent++;
    endtask

    // Close a burst: drop valid for a random gap, or start a fresh burst at once.
    task automatic end_of_item();
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 40);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    endtask

    // Hold off the sender until every outstanding result has come back.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.results_due.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [31:0] w;
        logic [31:0] a;
        logic [31:0] b;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: each operation at least once, with the corner cases that matter to it.
        // ADDU wraps at the top, SUBU borrows through zero.
        send_instr(enc_r(FN_ADDU, 5'd1, 5'd2, 5'd3, 5'd0), 32'h0000_0000,
                   32'hffff_ffff, 32'h0000_0001);
        send_instr(enc_r(FN_SUBU, 5'd4, 5'd5, 5'd31, 5'd0), 32'hffff_fffc,
                   32'h0000_0000, 32'h0000_0001);
        send_instr(enc_r(FN_AND, 5'd31, 5'd31, 5'd7, 5'd0), 32'h0040_0000,
                   32'hf0f0_f0f0, 32'h3c3c_3c3c);
        send_instr(enc_r(FN_OR, 5'd8, 5'd9, 5'd10, 5'd0), 32'h0040_0004,
                   32'h8000_0000, 32'h0000_0001);
        send_instr(enc_r(FN_NOR, 5'd0, 5'd0, 5'd11, 5'd0), 32'h0040_0008,
                   32'h0000_0000, 32'h0000_0000);
        // SLTU must compare unsigned: 0 is below all ones.
        send_instr(enc_r(FN_SLTU, 5'd1, 5'd2, 5'd12, 5'd0), 32'h0040_000c,
                   32'h0000_0000, 32'hffff_ffff);
        // Shifts by the full amount; the rs field is junk and must be ignored.
        send_instr(enc_r(FN_SLL, 5'd31, 5'd2, 5'd13, 5'd31), 32'h0040_0010,
                   32'h1234_5678, 32'hffff_ffff);
        send_instr(enc_r(FN_SRL, 5'd17, 5'd2, 5'd14, 5'd31), 32'h0040_0014,
                   32'h1234_5678, 32'h8000_0000);
        send_instr(enc_r(FN_JR, 5'd31, 5'd0, 5'd0, 5'd0), 32'h0040_0018,
                   32'hdead_beef, 32'h0000_0000);
        // J with PC+4 wrapping to zero, JAL crossing into the top region.
        send_instr(enc_j(OP_J, 26'h3ff_ffff), 32'hffff_fffc,
                   32'h0000_0000, 32'h0000_0000);
        send_instr(enc_j(OP_JAL, 26'h000_0001), 32'hefff_fffc,
                   32'h0000_0000, 32'h0000_0000);
        // Immediates: sign extension for ADDIU/SLTIU/LW/SW, zero for ANDI/ORI.
        send_instr(enc_i(OP_ADDIU, 5'd1, 5'd15, 16'h8000), 32'h0040_001c,
                   32'h0000_0000, 32'h0000_0000);
        send_instr(enc_i(OP_ANDI, 5'd1, 5'd16, 16'hffff), 32'h0040_0020,
                   32'hffff_ffff, 32'h0000_0000);
        send_instr(enc_i(OP_ORI, 5'd1, 5'd17, 16'h8000), 32'h0040_0024,
                   32'h0000_0000, 32'h0000_0000);
        send_instr(enc_i(OP_SLTIU, 5'd1, 5'd18, 16'hffff), 32'h0040_0028,
                   32'hffff_fffe, 32'h0000_0000);
        send_instr(enc_i(OP_LUI, 5'd0, 5'd19, 16'hffff), 32'h0040_002c,
                   32'h1111_1111, 32'h0000_0000);
        send_instr(enc_i(OP_LW, 5'd29, 5'd20, 16'hfffc), 32'h0040_0030,
                   32'h0000_0000, 32'h0000_0000);
        send_instr(enc_i(OP_SW, 5'd29, 5'd21, 16'h7fff), 32'h0040_0034,
                   32'hffff_8000, 32'hcafe_f00d);
        // Branches: taken backwards, not taken, and the reverse for BNE.
        send_instr(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h8000), 32'h0000_0010,
                   32'h5555_5555, 32'h5555_5555);
        send_instr(enc_i(OP_BNE, 5'd1, 5'd2, 16'h0004), 32'h0040_0038,
                   32'h0000_0000, 32'h0000_0000);
        send_instr(enc_i(OP_BEQ, 5'd1, 5'd2, 16'h7fff), 32'h0040_003c,
                   32'h0000_0001, 32'h0000_0000);
        send_instr(enc_i(OP_BNE, 5'd1, 5'd2, 16'hffff), 32'hffff_fff8,
                   32'h0000_0000, 32'hffff_ffff);
        // Illegal opcode, and an unknown function code with junk in shamt.
        send_instr(32'hffff_ffff, 32'h0040_0040, 32'hffff_ffff, 32'hffff_ffff);
        send_instr(enc_r(6'h3f, 5'd1, 5'd2, 5'd3, 5'd7), 32'h0040_0044,
                   32'h1234_5678, 32'h9abc_def0);
        // Write to r0 stays a write; shamt is ignored outside the shifts.
        send_instr(enc_r(FN_ADDU, 5'd1, 5'd2, 5'd0, 5'd31), 32'h0040_0048,
                   32'h0000_0005, 32'h0000_0007);

        drain();

        // Random part: bursts of random length, one pause to empty the pipe.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            w = rand_instr();
            a = rand_operand();
            b = ($urandom_range(0, 3) == 0) ? a : rand_operand();
            send_instr(w, $urandom(), a, b);
            if (i == DRAIN_POINT)
                drain();
            else
                end_of_item();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("sent %0d instructions, checked %0d results", n_sent, tracker.n_checked);
        $display("redirects %0d, memory accesses %0d, illegal words %0d, mismatches %0d",
                 tracker.n_redirect, tracker.n_mem, tracker.n_illegal, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.results_due.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
`default_nettype wire
